// ===== hw/rtl/slm_pkg.sv =====
// Package: item types, configuration layout, widths and reset values of the stereo level monitor.
package slm_pkg;

    localparam int ENERGY_WIDTH_DEF = 48;
    localparam int COUNT_WIDTH_DEF  = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_RATIO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEVEL_SQ  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STATIC_FRAC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OK_MIN_FRAMES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OK_MIN_PEAK   = 3'd4;

    localparam logic [9:0]  RST_SELECT_RATIO  = 10'd369;
    localparam logic [15:0] RST_LOW_LEVEL_SQ  = 16'd25;
    localparam logic [8:0]  RST_STATIC_FRAC   = 9'd205;
    localparam logic [31:0] RST_OK_MIN_FRAMES = 32'd16000;
    localparam logic [14:0] RST_OK_MIN_PEAK   = 15'd20;

    localparam logic [14:0] PEAK_MAX     = 15'h7FFF;
    localparam logic [15:0] SAMPLE_POS_FS = 16'h7FFF;
    localparam logic [15:0] SAMPLE_NEG_FS = 16'h8000;
    localparam logic [63:0] FIELD48_MAX  = 64'h0000_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic              kind;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
    } t_in_item;

    typedef struct packed {
        logic              is_report;
        logic signed [15:0] mono_sample;
        logic              selected_channel;
        logic [14:0]       window_peak;
        logic [31:0]       window_zeros;
        logic [31:0]       window_clips;
        logic [31:0]       window_frames;
        logic [47:0]       left_energy;
        logic [47:0]       right_energy;
        logic              level_fault;
        logic              signal_static;
        logic              mic_ok;
    } t_out_item;

    typedef struct packed {
        logic [9:0]  select_ratio_q8;
        logic [15:0] low_level_sq;
        logic [8:0]  static_fraction_q8;
        logic [31:0] mic_ok_min_frames;
        logic [14:0] mic_ok_min_peak;
    } t_cfg;

    // Commit of the item held in the front stage, and whether that item is a report.
    typedef struct packed {
        logic commit;
        logic report;
    } t_step;

endpackage

// ===== hw/rtl/slm_lane.sv =====
// One channel lane: squares the sample and keeps the saturating sum of squares, cleared on a report.
module slm_lane import slm_pkg::*; #(
    parameter int ENERGY_WIDTH = ENERGY_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic signed [15:0]      i_sample,
    input  t_step                   i_step,
    output logic [15:0]             o_mag,
    output logic [ENERGY_WIDTH-1:0] o_sum
);

    localparam int AW = ENERGY_WIDTH + 1;

    logic signed [31:0]      w_sq_full;
    logic [15:0]             w_mag;
    logic [30:0]             r_sq;
    logic [15:0]             r_mag;
    logic [ENERGY_WIDTH-1:0] r_sum;
    logic [ENERGY_WIDTH-1:0] n_sum;
    logic [AW-1:0]           w_acc;

    assign w_sq_full = i_sample * i_sample;
    assign w_mag     = i_sample[15] ? (~$unsigned(i_sample) + 16'd1) : $unsigned(i_sample);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sq  <= w_sq_full[30:0];
            r_mag <= w_mag;
        end
    end

    assign w_acc = {1'b0, r_sum} + AW'(r_sq);

    always_comb begin
        n_sum = r_sum;
        if (i_step.commit) begin
            if (i_step.report) begin
                n_sum = '0;
            end else begin
                n_sum = w_acc[ENERGY_WIDTH] ? '1 : w_acc[ENERGY_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    assign o_mag = r_mag;
    assign o_sum = r_sum;

endmodule

// ===== hw/rtl/slm_merge.sv =====
// Merge stage: mono select, window counters, report flags, channel choice and output register.
module slm_merge import slm_pkg::*; #(
    parameter int ENERGY_WIDTH = ENERGY_WIDTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_step                   i_step,
    input  t_cfg                    i_cfg,
    input  logic signed [15:0]      i_left,
    input  logic signed [15:0]      i_right,
    input  logic [15:0]             i_left_mag,
    input  logic [15:0]             i_right_mag,
    input  logic [ENERGY_WIDTH-1:0] i_left_sum,
    input  logic [ENERGY_WIDTH-1:0] i_right_sum,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    output t_out_item               o_out_item
);

    localparam int LFW = 16 + COUNT_WIDTH;
    localparam int SW  = (ENERGY_WIDTH > LFW) ? ENERGY_WIDTH : LFW;
    localparam int FW  = COUNT_WIDTH + 9;
    localparam int PW  = ENERGY_WIDTH + 10;

    logic [COUNT_WIDTH-1:0] r_frames, r_zeros, r_clips, r_unch;
    logic [COUNT_WIDTH-1:0] n_frames, n_zeros, n_clips, n_unch;
    logic [14:0]            r_peak, n_peak;
    logic [15:0]            r_prev, n_prev;
    logic                   r_chan, n_chan;
    logic                   r_out_valid;
    t_out_item              r_out, n_out;

    logic [15:0]    w_mono;
    logic [15:0]    w_mag;
    logic [14:0]    w_mag15;
    logic [LFW-1:0] w_low_frames;
    logic           w_sil_l, w_sil_r, w_err, w_stat, w_ok;
    logic [FW-1:0]  w_unch_sh, w_frac_frames;
    logic [PW-1:0]  w_l256, w_r256, w_l_ratio, w_r_ratio;
    logic [63:0]    w_l64, w_r64;

    assign w_mono  = r_chan ? $unsigned(i_right) : $unsigned(i_left);
    assign w_mag   = r_chan ? i_right_mag : i_left_mag;
    assign w_mag15 = w_mag[15] ? PEAK_MAX : w_mag[14:0];

    assign w_low_frames = i_cfg.low_level_sq * r_frames;
    assign w_sil_l = (r_frames == '0) ? (i_cfg.low_level_sq != '0)
                                      : (SW'(i_left_sum) < SW'(w_low_frames));
    assign w_sil_r = (r_frames == '0) ? (i_cfg.low_level_sq != '0)
                                      : (SW'(i_right_sum) < SW'(w_low_frames));
    assign w_err   = w_sil_l && w_sil_r;

    assign w_unch_sh     = {1'b0, r_unch, 8'd0};
    assign w_frac_frames = i_cfg.static_fraction_q8 * r_frames;
    assign w_stat        = !w_err && (w_unch_sh > w_frac_frames);
    assign w_ok          = (32'(r_frames) > i_cfg.mic_ok_min_frames)
                        && (r_peak > i_cfg.mic_ok_min_peak);

    assign w_l256    = {2'b00, i_left_sum, 8'd0};
    assign w_r256    = {2'b00, i_right_sum, 8'd0};
    assign w_l_ratio = i_left_sum * i_cfg.select_ratio_q8;
    assign w_r_ratio = i_right_sum * i_cfg.select_ratio_q8;

    assign w_l64 = 64'(i_left_sum);
    assign w_r64 = 64'(i_right_sum);

    always_comb begin
        n_frames = r_frames;
        n_zeros  = r_zeros;
        n_clips  = r_clips;
        n_unch   = r_unch;
        n_peak   = r_peak;
        n_prev   = r_prev;
        n_chan   = r_chan;
        n_out    = '0;
        if (i_step.report) begin
            priority if (w_l256 > w_r_ratio) begin
                n_chan = 1'b0;
            end else if (w_r256 > w_l_ratio) begin
                n_chan = 1'b1;
            end else begin
                n_chan = r_chan;
            end
            n_out.is_report        = 1'b1;
            n_out.selected_channel = n_chan;
            n_out.window_peak      = r_peak;
            n_out.window_zeros     = 32'(r_zeros);
            n_out.window_clips     = 32'(r_clips);
            n_out.window_frames    = 32'(r_frames);
            n_out.left_energy      = (w_l64 > FIELD48_MAX) ? '1 : w_l64[47:0];
            n_out.right_energy     = (w_r64 > FIELD48_MAX) ? '1 : w_r64[47:0];
            n_out.level_fault      = w_err;
            n_out.signal_static    = w_stat;
            n_out.mic_ok           = w_ok;
            n_frames = '0;
            n_zeros  = '0;
            n_clips  = '0;
            n_unch   = '0;
            n_peak   = '0;
        end else begin
            if (r_frames != '1) n_frames = r_frames + 1'b1;
            if (w_mag15 > r_peak) n_peak = w_mag15;
            if (w_mono == '0 && r_zeros != '1) n_zeros = r_zeros + 1'b1;
            if ((w_mono == SAMPLE_POS_FS || w_mono == SAMPLE_NEG_FS) && r_clips != '1) begin
                n_clips = r_clips + 1'b1;
            end
            if (w_mono == r_prev && r_unch != '1) n_unch = r_unch + 1'b1;
            n_prev = w_mono;
            n_out.mono_sample      = $signed(w_mono);
            n_out.selected_channel = r_chan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames    <= '0;
            r_zeros     <= '0;
            r_clips     <= '0;
            r_unch      <= '0;
            r_peak      <= '0;
            r_prev      <= '0;
            r_chan      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_step.commit) begin
                r_frames    <= n_frames;
                r_zeros     <= n_zeros;
                r_clips     <= n_clips;
                r_unch      <= n_unch;
                r_peak      <= n_peak;
                r_prev      <= n_prev;
                r_chan      <= n_chan;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_report_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step.commit && i_step.report |=> r_frames == '0 && r_peak == '0)
        else $error("window statistics not cleared after report");

    a_frame_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step.commit && !i_step.report && r_frames != '1 |=> r_frames == $past(r_frames) + 1'b1)
        else $error("frame count did not advance");

    a_report_mono_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.is_report |-> r_out.mono_sample == '0)
        else $error("report carries a mono sample");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.level_fault && r_out.signal_static))
        else $error("static flag raised together with level fault");

    a_frame_no_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.is_report |-> r_out.window_frames == '0 && !r_out.mic_ok)
        else $error("frame item carries window figures");

endmodule

// ===== hw/rtl/stereo_level_monitor_channel_select.sv =====
// Top level: stereo level monitor with channel selection, front stage, lanes, merge and config.
//
//   port group   direction  handshake               payload
//   input item   in         i_in_valid/o_in_stall   i_in_item  (t_in_item)
//   result item  out        o_out_valid/i_out_stall o_out_item (t_out_item)
//   config       in         i_cfg_we                i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the output is not stalled; an accepted item passes the front stage
// (with the two lane squarers), then the accumulate/merge stage and output register.
// Reset is synchronous: clears stage valids, window statistics, channel choice (left) and
// loads the config defaults.
// A stalled output holds its register; a full front stage then waits and stalls the input until the output drains.
module stereo_level_monitor_channel_select import slm_pkg::*; #(
    parameter int ENERGY_WIDTH = ENERGY_WIDTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_item,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_item,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg               r_cfg;
    logic               r_s1_valid;
    logic               r_s1_kind;
    logic signed [15:0] r_s1_left;
    logic signed [15:0] r_s1_right;
    logic               w_load;
    t_step              w_step;

    logic [15:0]             w_left_mag, w_right_mag;
    logic [ENERGY_WIDTH-1:0] w_left_sum, w_right_sum;

    assign w_step.commit = r_s1_valid && (!o_out_valid || !i_out_stall);
    assign w_step.report = r_s1_kind;
    assign o_in_stall    = r_s1_valid && !w_step.commit;
    assign w_load        = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.select_ratio_q8    <= RST_SELECT_RATIO;
            r_cfg.low_level_sq       <= RST_LOW_LEVEL_SQ;
            r_cfg.static_fraction_q8 <= RST_STATIC_FRAC;
            r_cfg.mic_ok_min_frames  <= RST_OK_MIN_FRAMES;
            r_cfg.mic_ok_min_peak    <= RST_OK_MIN_PEAK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SELECT_RATIO:  r_cfg.select_ratio_q8    <= i_cfg_data[9:0];
                CFG_LOW_LEVEL_SQ:  r_cfg.low_level_sq       <= i_cfg_data[15:0];
                CFG_STATIC_FRAC:   r_cfg.static_fraction_q8 <= i_cfg_data[8:0];
                CFG_OK_MIN_FRAMES: r_cfg.mic_ok_min_frames  <= i_cfg_data[31:0];
                CFG_OK_MIN_PEAK:   r_cfg.mic_ok_min_peak    <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_load) begin
            r_s1_valid <= 1'b1;
        end else if (w_step.commit) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_s1_kind  <= i_in_item.kind;
            r_s1_left  <= i_in_item.left_sample;
            r_s1_right <= i_in_item.right_sample;
        end
    end

    slm_lane #(.ENERGY_WIDTH(ENERGY_WIDTH)) u_lane_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_sample (i_in_item.left_sample),
        .i_step   (w_step),
        .o_mag    (w_left_mag),
        .o_sum    (w_left_sum)
    );

    slm_lane #(.ENERGY_WIDTH(ENERGY_WIDTH)) u_lane_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_sample (i_in_item.right_sample),
        .i_step   (w_step),
        .o_mag    (w_right_mag),
        .o_sum    (w_right_sum)
    );

    slm_merge #(
        .ENERGY_WIDTH (ENERGY_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_cfg       (r_cfg),
        .i_left      (r_s1_left),
        .i_right     (r_s1_right),
        .i_left_mag  (w_left_mag),
        .i_right_mag (w_right_mag),
        .i_left_sum  (w_left_sum),
        .i_right_sum (w_right_sum),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== tb/sv/slm_tb_pkg.sv =====
// Item codes and the window-statistics scoreboard for the stereo level monitor bench.
package slm_tb_pkg;

    import slm_pkg::*;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;
    localparam logic CH_LEFT    = 1'b0;
    localparam logic CH_RIGHT   = 1'b1;

    localparam logic [63:0] ENERGY_SAT = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] COUNT_SAT  = 64'h0000_0000_FFFF_FFFF;
    localparam int          PRINT_CAP  = 100;

    class level_scoreboard;
        t_cfg        regs;
        logic [63:0] left_sum;
        logic [63:0] right_sum;
        logic [63:0] frames;
        logic [63:0] zeros;
        logic [63:0] clips;
        logic [63:0] unchanged;
        logic [14:0] peak;
        logic [15:0] last_mono;
        logic        channel;
        t_out_item   expected_q[$];
        int          mismatches;
        int          results_seen;

        function new();
            regs = '{RST_SELECT_RATIO, RST_LOW_LEVEL_SQ, RST_STATIC_FRAC,
                     RST_OK_MIN_FRAMES, RST_OK_MIN_PEAK};
            clear_window();
            last_mono    = '0;
            channel      = CH_LEFT;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void clear_window();
            left_sum  = '0;
            right_sum = '0;
            frames    = '0;
            zeros     = '0;
            clips     = '0;
            unchanged = '0;
            peak      = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SELECT_RATIO:  regs.select_ratio_q8    = data[9:0];
                CFG_LOW_LEVEL_SQ:  regs.low_level_sq       = data[15:0];
                CFG_STATIC_FRAC:   regs.static_fraction_q8 = data[8:0];
                CFG_OK_MIN_FRAMES: regs.mic_ok_min_frames  = data[31:0];
                CFG_OK_MIN_PEAK:   regs.mic_ok_min_peak    = data[14:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] sat_add(logic [63:0] acc, logic [63:0] x, logic [63:0] max);
            if (acc > max || x > max - acc) return max;
            return acc + x;
        endfunction

        function logic [16:0] magnitude(logic [15:0] s);
            return s[15] ? 17'h10000 - {1'b0, s} : {1'b0, s};
        endfunction

        // empty window: mean square taken as zero
        function logic silent(logic [63:0] sum);
            if (frames == 0) return regs.low_level_sq != 0;
            return sum < 64'(regs.low_level_sq) * frames;
        endfunction

        function void accept_input(t_in_item it);
            t_out_item   want;
            logic [16:0] lmag;
            logic [16:0] rmag;
            logic [16:0] mag;
            logic [15:0] mono;
            logic        err;
            logic        stat;
            logic        ok;
            want = '0;
            if (it.kind == KIND_FRAME) begin
                lmag = magnitude(it.left_sample);
                rmag = magnitude(it.right_sample);
                mono = (channel == CH_RIGHT) ? it.right_sample : it.left_sample;
                mag  = (channel == CH_RIGHT) ? rmag : lmag;
                left_sum  = sat_add(left_sum, 64'(lmag) * 64'(lmag), ENERGY_SAT);
                right_sum = sat_add(right_sum, 64'(rmag) * 64'(rmag), ENERGY_SAT);
                frames    = sat_add(frames, 64'd1, COUNT_SAT);
                if (mag > 17'(PEAK_MAX)) mag = 17'(PEAK_MAX);
                if (mag[14:0] > peak) peak = mag[14:0];
                if (mono == 16'h0000) zeros = sat_add(zeros, 64'd1, COUNT_SAT);
                if (mono == SAMPLE_POS_FS || mono == SAMPLE_NEG_FS)
                    clips = sat_add(clips, 64'd1, COUNT_SAT);
                if (mono == last_mono) unchanged = sat_add(unchanged, 64'd1, COUNT_SAT);
                last_mono = mono;
                want.mono_sample      = mono;
                want.selected_channel = channel;
            end else begin
                err  = silent(left_sum) && silent(right_sum);
                stat = !err && ((unchanged << 8) > 64'(regs.static_fraction_q8) * frames);
                ok   = (frames > 64'(regs.mic_ok_min_frames)) && (peak > regs.mic_ok_min_peak);
                if ((left_sum << 8) > right_sum * 64'(regs.select_ratio_q8))
                    channel = CH_LEFT;
                else if ((right_sum << 8) > left_sum * 64'(regs.select_ratio_q8))
                    channel = CH_RIGHT;
                want.is_report        = 1'b1;
                want.selected_channel = channel;
                want.window_peak      = peak;
                want.window_zeros     = zeros[31:0];
                want.window_clips     = clips[31:0];
                want.window_frames    = frames[31:0];
                want.left_energy      = left_sum[47:0];
                want.right_energy     = right_sum[47:0];
                want.level_fault      = err;
                want.signal_static    = stat;
                want.mic_ok           = ok;
                clear_window();
            end
            expected_q.push_back(want);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                          results_seen, name, got, want));
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing expected", results_seen));
                return;
            end
            want = expected_q.pop_front();
            compare_field("is_report", got.is_report, want.is_report);
            compare_field("mono_sample", got.mono_sample, want.mono_sample);
            compare_field("selected_channel", got.selected_channel, want.selected_channel);
            compare_field("window_peak", got.window_peak, want.window_peak);
            compare_field("window_zeros", got.window_zeros, want.window_zeros);
            compare_field("window_clips", got.window_clips, want.window_clips);
            compare_field("window_frames", got.window_frames, want.window_frames);
            compare_field("left_energy", got.left_energy, want.left_energy);
            compare_field("right_energy", got.right_energy, want.right_energy);
            compare_field("level_fault", got.level_fault, want.level_fault);
            compare_field("signal_static", got.signal_static, want.signal_static);
            compare_field("mic_ok", got.mic_ok, want.mic_ok);
        endtask
    endclass

endpackage

// ===== tb/sv/tb_stereo_level_monitor_channel_select.sv =====
// Bench top: drives frames, window closes and register writes into the level monitor.
module tb_stereo_level_monitor_channel_select;

    import slm_pkg::*;
    import slm_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD      = 120;
    localparam int PHASE_ITEMS    = 120;

    typedef enum int {
        WIN_RANDOM, WIN_LEFT_LOUD, WIN_RIGHT_LOUD, WIN_QUIET, WIN_STATIC, WIN_EDGES,
        WIN_BALANCED
    } t_window_style;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_item   = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_out_item             out_item;
    logic                  out_stall = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    bit              tx_bursty     = 1'b0;
    bit              rx_bursty     = 1'b0;
    bit              long_hold_req = 1'b0;
    int              sent_items    = 0;
    level_scoreboard board;

    stereo_level_monitor_channel_select dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [15:0] quiet_sample();
        return 16'($urandom_range(0, 16)) - 16'd8;
    endfunction

    function automatic logic [15:0] mid_sample();
        return 16'($urandom_range(0, 4000)) - 16'd2000;
    endfunction

    function automatic logic [15:0] edge_sample();
        case ($urandom_range(0, 5))
            0:       return SAMPLE_POS_FS;
            1:       return SAMPLE_NEG_FS;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'h0001;
            default: return 16'h8001;
        endcase
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.select_ratio_q8    = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 255))
                                                           : 10'($urandom_range(256, 1023));
        c.low_level_sq       = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 400))
                                                           : 16'($urandom);
        c.static_fraction_q8 = 9'($urandom_range(0, 256));
        c.mic_ok_min_frames  = 32'($urandom_range(0, 40));
        c.mic_ok_min_peak    = ($urandom_range(0, 1) == 0) ? 15'($urandom_range(0, 2000))
                                                           : 15'($urandom);
        return c;
    endfunction

    task automatic send_item(input t_in_item it);
        if (tx_bursty && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.accept_input(it);
        sent_items++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.set_reg(idx, data);
    endtask

    // upper data bits beyond each register carry noise
    task automatic write_cfg(input t_cfg c);
        write_reg(CFG_SELECT_RATIO, {22'($urandom), c.select_ratio_q8});
        write_reg(CFG_LOW_LEVEL_SQ, {16'($urandom), c.low_level_sq});
        write_reg(CFG_STATIC_FRAC, {23'($urandom), c.static_fraction_q8});
        write_reg(CFG_OK_MIN_FRAMES, c.mic_ok_min_frames);
        write_reg(CFG_OK_MIN_PEAK, {17'($urandom), c.mic_ok_min_peak});
        cfg_we <= 1'b0;
    endtask

    task automatic send_window(input t_window_style style, input int n_frames);
        t_in_item    it;
        logic [15:0] held;
        held = ($urandom_range(0, 1) == 0) ? edge_sample() : 16'($urandom);
        for (int k = 0; k < n_frames; k++) begin
            it.kind = KIND_FRAME;
            case (style)
                WIN_LEFT_LOUD: begin
                    it.left_sample  = 16'($urandom);
                    it.right_sample = quiet_sample();
                end
                WIN_RIGHT_LOUD: begin
                    it.left_sample  = quiet_sample();
                    it.right_sample = 16'($urandom);
                end
                WIN_QUIET: begin
                    it.left_sample  = quiet_sample();
                    it.right_sample = quiet_sample();
                end
                WIN_STATIC: begin
                    it.left_sample  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : held;
                    it.right_sample = ($urandom_range(0, 7) == 0) ? 16'($urandom) : held;
                end
                WIN_EDGES: begin
                    it.left_sample  = edge_sample();
                    it.right_sample = edge_sample();
                end
                WIN_BALANCED: begin
                    it.left_sample  = mid_sample();
                    it.right_sample = mid_sample();
                end
                default: begin
                    it.left_sample  = 16'($urandom);
                    it.right_sample = 16'($urandom);
                end
            endcase
            send_item(it);
        end
        it.kind         = KIND_CLOSE;
        it.left_sample  = 16'($urandom);
        it.right_sample = 16'($urandom);
        send_item(it);
    endtask

    task automatic run_phase(input t_cfg c, input bit bursty);
        int first;
        wait_for_results();
        write_cfg(c);
        tx_bursty = bursty;
        rx_bursty = bursty;
        first     = sent_items;
        while (sent_items - first < PHASE_ITEMS)
            send_window(t_window_style'($urandom_range(0, 6)),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60)
                                                    : $urandom_range(0, 20));
    endtask

    // result side
    initial begin
        int hold_left;
        hold_left = 0;
        while (!rst_n) @(posedge clk);
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) board.check_result(out_item);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                out_stall    <= 1'b1;
            end else if (rx_bursty && $urandom_range(0, 5) == 0) begin
                hold_left  = $urandom_range(0, 15);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (!rst_n) @(posedge clk);
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("tb_stereo_level_monitor_channel_select failed");
        $finish;
    end

    initial begin
        t_cfg c;
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items at reset settings
        send_item(t_in_item'{KIND_FRAME, 16'h0000, 16'h0000});
        send_item(t_in_item'{KIND_FRAME, 16'h7FFF, 16'h8000});
        send_item(t_in_item'{KIND_FRAME, 16'h8000, 16'h7FFF});
        send_item(t_in_item'{KIND_FRAME, 16'hFFFF, 16'h0001});
        send_item(t_in_item'{KIND_FRAME, 16'h0001, 16'hFFFF});
        send_item(t_in_item'{KIND_CLOSE, 16'hFFFF, 16'hFFFF});
        send_item(t_in_item'{KIND_CLOSE, 16'h0000, 16'h0000});
        repeat (4) send_item(t_in_item'{KIND_FRAME, 16'd5, 16'd20000});
        send_item(t_in_item'{KIND_CLOSE, 16'h5555, 16'hAAAA});
        send_item(t_in_item'{KIND_FRAME, 16'd100, 16'h8000});
        send_item(t_in_item'{KIND_FRAME, 16'd100, 16'h0000});
        send_item(t_in_item'{KIND_FRAME, 16'd100, 16'h0000});
        send_item(t_in_item'{KIND_CLOSE, 16'hAAAA, 16'h5555});
        repeat (4) send_item(t_in_item'{KIND_FRAME, -16'sd20000, 16'sd3});
        send_item(t_in_item'{KIND_CLOSE, 16'h0000, 16'hFFFF});
        send_item(t_in_item'{KIND_FRAME, 16'sd7, 16'sd7});
        send_item(t_in_item'{KIND_CLOSE, 16'hFFFF, 16'h0000});

        long_hold_req = 1'b1;
        run_phase(t_cfg'{10'd256, 16'd0, 9'd0, 32'd0, 15'd0}, 1'b1);
        c = t_cfg'{10'd1023, 16'hFFFF, 9'd256, 32'hFFFF_FFFF, 15'h7FFF};
        run_phase(c, 1'b1);
        run_phase(t_cfg'{10'd0, 16'd25, 9'd511, 32'd3, 15'd100}, 1'b1);
        repeat (4) run_phase(random_cfg(), 1'b1);
        c = t_cfg'{RST_SELECT_RATIO, RST_LOW_LEVEL_SQ, RST_STATIC_FRAC,
                   RST_OK_MIN_FRAMES, RST_OK_MIN_PEAK};
        run_phase(c, 1'b0);

        send_item(t_in_item'{KIND_CLOSE, 16'h0000, 16'h0000});
        send_window(WIN_RANDOM, 10);

        wait_for_results();
        repeat (4) @(posedge clk);
        if (board.mismatches == 0 && board.expected_q.size() == 0) begin
            $display("tb_stereo_level_monitor_channel_select passed");
        end else begin
            $display("tb_stereo_level_monitor_channel_select failed");
        end
        $finish;
    end

endmodule

// ===== stereo_level_monitor_channel_select.f =====
hw/rtl/slm_pkg.sv
hw/rtl/slm_lane.sv
hw/rtl/slm_merge.sv
hw/rtl/stereo_level_monitor_channel_select.sv
tb/sv/slm_tb_pkg.sv
tb/sv/tb_stereo_level_monitor_channel_select.sv
